// ===== hw/rtl/tfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfsc_pkg
// Shared types and byte constants for the TLS flow signature classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsc_pkg;

  localparam logic [7:0] RecHandshake = 8'h16;
  localparam logic [7:0] RecAppData   = 8'h17;
  localparam logic [7:0] RecAlert     = 8'h15;
  localparam logic [7:0] RecChgCipher = 8'h14;
  localparam logic [7:0] VerMajor     = 8'h03;
  localparam logic [7:0] V2HelloA     = 8'h80;
  localparam logic [7:0] V2HelloB     = 8'h81;
  localparam logic [15:0] V2Tail      = 16'h0103;
  localparam logic [31:0] ShortHsWord = 32'h1600_0000;
  // "<!DO"
  localparam logic [31:0] DoctypeWord = 32'h3C21_444F;

  // Per-byte compare flags of one direction (first stage)
  typedef struct packed {
    logic hs_type;
    logic app_type;
    logic alert_type;
    logic chg_type;
    logic v2_type;
    logic major3;
    logic minor0;
    logic minor13;
    logic v2_tail;
    logic short_word;
    logic doctype;
    logic len0;
    logic len1;
  } tfsc_byte_t;

  // Signature classes of one direction (second stage)
  typedef struct packed {
    logic ssl3_hs;
    logic tls_hs;
    logic rec;      // application data, alert or change cipher
    logic ssl2;
    logic doctype;
    logic len0;
  } tfsc_cls_t;

  // Stage advance enables
  typedef struct packed {
    logic a;
    logic b;
  } tfsc_adv_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tls_flow_signature_classifier.sv =====
// ----------------------------------------------------------------------------
// tls_flow_signature_classifier
// Flags a flow as SSL/TLS from the leading bytes and lengths of both directions.
// ----------------------------------------------------------------------------
// An accepted request passes the byte compare, class and output registers in turn.
// Throughput: one request per cycle unless stalled; three register stages
// (byte compares, per-direction classes, rule combine with output register).
// A stall on the output holds the full pipeline; empty stages still fill.
// Reset clears the stage valid bits only; the data registers are not reset.
`default_nettype none

module tls_flow_signature_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output      logic        stall_o,
  input  wire logic [31:0] out_bytes_i,
  input  wire logic [15:0] out_len_i,
  input  wire logic [31:0] in_bytes_i,
  input  wire logic [15:0] in_len_i,
  output      logic        valid_o,
  input  wire logic        stall_i,
  output      logic        is_tls_o
);

  logic va_q, vb_q, vc_q;
  logic en_c;
  tfsc_pkg::tfsc_adv_t adv;

  // Advance a stage when it is empty or its successor advances
  assign en_c   = !vc_q || !stall_i;
  assign adv.b  = !vb_q || en_c;
  assign adv.a  = !va_q || adv.b;
  assign stall_o = !adv.a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (adv.a) va_q <= valid_i;
      if (adv.b) vb_q <= va_q;
      if (en_c)  vc_q <= vb_q;
    end
  end

  tfsc_pkg::tfsc_cls_t oc, ic;

  tfsc_dir_cls u_out_cls (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .bytes_i (out_bytes_i),
    .len_i   (out_len_i),
    .cls_o   (oc)
  );

  tfsc_dir_cls u_in_cls (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .bytes_i (in_bytes_i),
    .len_i   (in_len_i),
    .cls_o   (ic)
  );

  logic o_hs, i_hs;
  logic tls_d, tls_q;

  always_comb begin
    o_hs  = oc.ssl3_hs || oc.tls_hs;
    i_hs  = ic.ssl3_hs || ic.tls_hs;
    tls_d = (o_hs && i_hs) ||
            (oc.tls_hs && ic.rec) ||
            (ic.tls_hs && oc.rec) ||
            (oc.tls_hs && ic.doctype && !oc.len0) ||
            (ic.tls_hs && oc.doctype && !ic.len0) ||
            ((o_hs || oc.len0) && ic.ssl2) ||
            ((i_hs || ic.len0) && oc.ssl2);
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      tls_q <= tls_d;
    end
  end

  assign valid_o  = vc_q;
  assign is_tls_o = tls_q;

  // An accepted request always lands in the first stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> va_q)
    else $error("accepted request not captured");

  // An empty output stage never backs up the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vc_q |-> !stall_o)
    else $error("stall raised with free output stage");

  // A held first stage keeps its request
  a_hold_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && stall_o) |=> va_q)
    else $error("request dropped from first stage under stall");

  // Output may only stall the pipe while a result waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (vc_q && stall_i && vb_q && va_q))
    else $error("input stall without full pipeline");

endmodule

`default_nettype wire

// ===== hw/rtl/tfsc_dir_cls.sv =====
// ----------------------------------------------------------------------------
// tfsc_dir_cls
// Two-stage classifier for one direction: byte compares, then classes.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsc_dir_cls (
  input  wire logic                clk_i,
  input  wire tfsc_pkg::tfsc_adv_t adv_i,
  input  wire logic [31:0]         bytes_i,
  input  wire logic [15:0]         len_i,
  output tfsc_pkg::tfsc_cls_t      cls_o
);

  tfsc_pkg::tfsc_byte_t flg_d, flg_q;
  tfsc_pkg::tfsc_cls_t  cls_d, cls_q;

  logic [7:0] b0, b1, b2;

  assign b0 = bytes_i[31:24];
  assign b1 = bytes_i[23:16];
  assign b2 = bytes_i[15:8];

  always_comb begin
    flg_d.hs_type    = (b0 == tfsc_pkg::RecHandshake);
    flg_d.app_type   = (b0 == tfsc_pkg::RecAppData);
    flg_d.alert_type = (b0 == tfsc_pkg::RecAlert);
    flg_d.chg_type   = (b0 == tfsc_pkg::RecChgCipher);
    flg_d.v2_type    = (b0 == tfsc_pkg::V2HelloA) || (b0 == tfsc_pkg::V2HelloB);
    flg_d.major3     = (b1 == tfsc_pkg::VerMajor);
    flg_d.minor0     = (b2 == 8'h00);
    flg_d.minor13    = (b2 >= 8'h01) && (b2 <= 8'h03);
    flg_d.v2_tail    = (bytes_i[15:0] == tfsc_pkg::V2Tail);
    flg_d.short_word = (bytes_i == tfsc_pkg::ShortHsWord);
    flg_d.doctype    = (bytes_i == tfsc_pkg::DoctypeWord);
    flg_d.len0       = (len_i == 16'd0);
    flg_d.len1       = (len_i == 16'd1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.a) begin
      flg_q <= flg_d;
    end
  end

  logic short_hs;

  always_comb begin
    short_hs      = flg_q.len0 || (flg_q.len1 && flg_q.short_word);
    cls_d.ssl3_hs = short_hs || (flg_q.hs_type && flg_q.major3 && flg_q.minor0);
    cls_d.tls_hs  = short_hs || (flg_q.hs_type && flg_q.major3 && flg_q.minor13);
    cls_d.rec     = flg_q.major3 && ((flg_q.app_type && flg_q.minor13) ||
                    (flg_q.alert_type && (flg_q.minor0 || flg_q.minor13)) ||
                    (flg_q.chg_type && flg_q.minor13));
    cls_d.ssl2    = flg_q.v2_type && flg_q.v2_tail;
    cls_d.doctype = flg_q.doctype;
    cls_d.len0    = flg_q.len0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.b) begin
      cls_q <= cls_d;
    end
  end

  assign cls_o = cls_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TLS flow signature classifier: directed flow
// summaries, then random ones biased toward record headers, with an
// in-bench verdict predictor and random idling on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandPerPhase = 530;
  localparam int unsigned HoldCycles = 60;

  typedef struct packed {
    logic [31:0] ob;
    logic [15:0] ol;
    logic [31:0] ib;
    logic [15:0] il;
  } flow_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] out_bytes_i = '0;
  logic [15:0] out_len_i = '0;
  logic [31:0] in_bytes_i = '0;
  logic [15:0] in_len_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        is_tls_o;

  flow_req_t   req_q[$];
  logic        verdict_q[$];
  logic        req_taken = 1'b0;
  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 62;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_tls = 0;
  int unsigned n_errors = 0;
  int unsigned cycle = 0;
  logic        hold_arm = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  tls_flow_signature_classifier u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .out_bytes_i(out_bytes_i),
    .out_len_i  (out_len_i),
    .in_bytes_i (in_bytes_i),
    .in_len_i   (in_len_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .is_tls_o   (is_tls_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic hdr_hit(logic [31:0] w, logic [7:0] rtype,
                                   logic [7:0] lo, logic [7:0] hi);
    return w[31:24] == rtype && w[23:16] == tfsc_pkg::VerMajor &&
           w[15:8] >= lo && w[15:8] <= hi;
  endfunction

  function automatic logic short_hs(logic [31:0] w, logic [15:0] n);
    return n == 16'd0 || (n == 16'd1 && w == tfsc_pkg::ShortHsWord);
  endfunction

  function automatic logic is_record(logic [31:0] w);
    return hdr_hit(w, tfsc_pkg::RecAppData, 8'h01, 8'h03) ||
           hdr_hit(w, tfsc_pkg::RecAlert, 8'h00, 8'h03) ||
           hdr_hit(w, tfsc_pkg::RecChgCipher, 8'h01, 8'h03);
  endfunction

  function automatic logic is_v2_hello(logic [31:0] w);
    return (w[31:24] == tfsc_pkg::V2HelloA || w[31:24] == tfsc_pkg::V2HelloB) &&
           w[15:0] == tfsc_pkg::V2Tail;
  endfunction

  function automatic logic tls_verdict(flow_req_t r);
    logic o3, ot, i3, it, v;
    o3 = short_hs(r.ob, r.ol) || hdr_hit(r.ob, tfsc_pkg::RecHandshake, 8'h00, 8'h00);
    ot = short_hs(r.ob, r.ol) || hdr_hit(r.ob, tfsc_pkg::RecHandshake, 8'h01, 8'h03);
    i3 = short_hs(r.ib, r.il) || hdr_hit(r.ib, tfsc_pkg::RecHandshake, 8'h00, 8'h00);
    it = short_hs(r.ib, r.il) || hdr_hit(r.ib, tfsc_pkg::RecHandshake, 8'h01, 8'h03);
    v = ((o3 || ot) && (i3 || it)) ||
        (ot && is_record(r.ib)) || (it && is_record(r.ob)) ||
        (ot && r.ib == tfsc_pkg::DoctypeWord && r.ol != 16'd0) ||
        (it && r.ob == tfsc_pkg::DoctypeWord && r.il != 16'd0) ||
        ((ot || o3 || r.ol == 16'd0) && is_v2_hello(r.ib)) ||
        ((it || i3 || r.il == 16'd0) && is_v2_hello(r.ob));
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus
  // One direction: mostly well-formed record headers, some near misses and noise.
  function automatic logic [47:0] rand_dir();
    logic [31:0] w;
    logic [15:0] n;
    int unsigned pick;
    int unsigned lsel;
    w = $urandom;
    lsel = $urandom_range(0, 9);
    n = (lsel == 0) ? 16'd0 : (lsel == 1) ? 16'd1 : (lsel == 2) ? 16'hFFFF : 16'($urandom);
    pick = $urandom_range(0, 11);
    case (pick)
      0: n = 16'd0;
      1: begin
        w = tfsc_pkg::ShortHsWord;
        n = 16'd1;
      end
      2: w = {tfsc_pkg::RecHandshake, tfsc_pkg::VerMajor, 8'h00, w[7:0]};
      3: w = {tfsc_pkg::RecHandshake, tfsc_pkg::VerMajor, 8'($urandom_range(1, 3)), w[7:0]};
      4: w = {tfsc_pkg::RecAppData, tfsc_pkg::VerMajor, 8'($urandom_range(1, 3)), w[7:0]};
      5: w = {tfsc_pkg::RecAlert, tfsc_pkg::VerMajor, 8'($urandom_range(0, 3)), w[7:0]};
      6: w = {tfsc_pkg::RecChgCipher, tfsc_pkg::VerMajor, 8'($urandom_range(0, 4)), w[7:0]};
      7: w = {($urandom_range(0, 1) != 0) ? tfsc_pkg::V2HelloA : tfsc_pkg::V2HelloB,
              w[23:16], tfsc_pkg::V2Tail};
      8: w = tfsc_pkg::DoctypeWord;
      // near miss: record type with a bad version or minor
      9: w = {8'($urandom_range(8'h14, 8'h17)),
              ($urandom_range(0, 1) != 0) ? tfsc_pkg::VerMajor : w[23:16], w[15:0]};
      default: ;
    endcase
    return {w, n};
  endfunction

  function automatic flow_req_t rand_flow();
    flow_req_t r;
    {r.ob, r.ol} = rand_dir();
    {r.ib, r.il} = rand_dir();
    return r;
  endfunction

  task automatic push_req(logic [31:0] ob, logic [15:0] ol, logic [31:0] ib, logic [15:0] il);
    req_q.push_back('{ob: ob, ol: ol, ib: ib, il: il});
    n_queued++;
  endtask

  task automatic push_random(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      req_q.push_back(rand_flow());
      n_queued++;
    end
  endtask

  task automatic wait_accepted();
    while (n_accepted != n_queued) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin : drive
    flow_req_t nxt;
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else if (valid_i && !req_taken) begin
      // hold the stalled request
    end else if (req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
      nxt = req_q.pop_front();
      valid_i <= 1'b1;
      out_bytes_i <= nxt.ob;
      out_len_i <= nxt.ol;
      in_bytes_i <= nxt.ib;
      in_len_i <= nxt.il;
    end else begin
      valid_i <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off once armed
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      stall_i <= 1'b1;
      hold_left <= HoldCycles - 1;
      hold_used <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : monitor
    flow_req_t acc;
    logic exp_v;
    cycle++;
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle, verdict_q.size());
      $display("TEST FAILED");
      $finish;
    end
    req_taken <= valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o) begin
      acc = '{ob: out_bytes_i, ol: out_len_i, ib: in_bytes_i, il: in_len_i};
      verdict_q.push_back(tls_verdict(acc));
      n_accepted++;
    end
    if (rst_ni && valid_o && !stall_i) begin
      n_checked++;
      if (is_tls_o === 1'b1) n_tls++;
      if (verdict_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("cycle %0d: unexpected result is_tls=%b", cycle, is_tls_o);
      end else begin
        exp_v = verdict_q.pop_front();
        if (is_tls_o !== exp_v) begin
          n_errors++;
          if (n_errors <= 10)
            $display("cycle %0d: is_tls mismatch, expected %b got %b", cycle, exp_v, is_tls_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    // both empty, both one-byte 0x16
    push_req(32'h0000_0000, 16'd0, 32'h0000_0000, 16'd0);
    push_req(tfsc_pkg::ShortHsWord, 16'd1, tfsc_pkg::ShortHsWord, 16'd1);
    push_req(tfsc_pkg::ShortHsWord, 16'd2, tfsc_pkg::ShortHsWord, 16'd2);
    // handshake kinds, max length
    push_req(32'h1603_0042, 16'hFFFF, 32'h1603_0100, 16'hFFFF);
    push_req(32'h1603_0355, 16'd300, 32'h1703_0100, 16'd40);
    push_req(32'h1603_0200, 16'd5, 32'h1503_0000, 16'd7);
    push_req(32'h1403_03AA, 16'd6, 32'h1603_0101, 16'd512);
    push_req(32'h1603_0101, 16'd6, 32'h1403_0000, 16'd6);
    push_req(32'h1603_0000, 16'd9, 32'h1703_0300, 16'd9);
    // doctype against handshake, with and without length
    push_req(32'h1603_0100, 16'd80, tfsc_pkg::DoctypeWord, 16'd200);
    push_req(32'h1234_5678, 16'd0, tfsc_pkg::DoctypeWord, 16'd200);
    push_req(tfsc_pkg::DoctypeWord, 16'd4, 32'h1603_0300, 16'd0);
    // SSLv2 hello
    push_req(32'h8042_0103, 16'd70, 32'hDEAD_BEEF, 16'd0);
    push_req(32'h1603_0000, 16'd3, 32'h81FF_0103, 16'd90);
    push_req(32'h8000_0103, 16'd10, 32'h8100_0103, 16'd10);
    // bad minor, all ones, short payload still compared
    push_req(32'h1603_0400, 16'd4, 32'h1603_0400, 16'd4);
    push_req(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF, 16'd0);
    push_req(tfsc_pkg::DoctypeWord, 16'd4, tfsc_pkg::DoctypeWord, 16'd4);
    push_req(32'h1603_0100, 16'd1, 32'h1603_03FF, 16'd1);
    push_req(32'h0000_0000, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(32'h1503_03FF, 16'hFFFF, 32'h1603_0101, 16'd0);
    push_random(RandPerPhase);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait_accepted();
    tx_idle_pct = 62;
    rx_idle_pct = 23;
    push_random(RandPerPhase);
    wait_accepted();

    // no idling; one long receiver hold-off fills the pipeline
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_arm = 1'b1;
    push_random(RandPerPhase);
    wait_accepted();

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d flow summaries checked, %0d flagged as SSL/TLS, over three idling mixes",
             n_checked, n_tls);
    $display("%0d mismatches, %0d results left unmatched", n_errors, verdict_q.size());
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== tls_flow_signature_classifier.f =====
hw/rtl/tfsc_pkg.sv
hw/rtl/tfsc_dir_cls.sv
hw/rtl/tls_flow_signature_classifier.sv
tb/tb_top.sv
